// File: rtl/wrsd_pkg.sv
// shared types, constants and the gravity smoothing function of the wrist-raise detector
package wrsd_pkg;

  // ring history of gravity estimates: the newest entry and those before it
  localparam int HIST_DEPTH = 26;
  // entries kept in the shift line; the slot the next write would free is never read
  localparam int HIST_TAPS  = HIST_DEPTH - 1;

  localparam int AXIS_W      = 13;
  localparam int LIN_W       = AXIS_W + 1;
  localparam int SMOOTH_W    = AXIS_W + 4;
  localparam int MAG_W       = SMOOTH_W - 1;
  localparam int PROD_W      = 2 * AXIS_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int TIME_W      = 32;
  localparam int JITTER_W    = 13;
  localparam int PERP_W      = 26;
  localparam int TILT_W      = 13;
  localparam int HOLD_W      = 16;
  localparam int CMP_W       = LIN_W + 1;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 26;

  // g = (9 * g + a) / 10, the divide done as a multiply by a reciprocal
  localparam int SMOOTH_WEIGHT = 9;
  localparam int RECIP_10      = 52429;
  localparam int RECIP_SHIFT   = 19;
  localparam int RECIP_PROD_W  = 32;

  // register values after reset
  localparam logic [JITTER_W-1:0] JITTER_RESET = 13'd200;
  localparam logic [PERP_W-1:0]   PERP_RESET   = 26'd100000;
  localparam logic [TILT_W-1:0]   TILT_RESET   = 13'h1DA8;   // -600
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd60;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_JITTER = 2'd0,
    REG_PERP   = 2'd1,
    REG_TILT   = 2'd2,
    REG_HOLD   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_t;

  typedef logic [2:0][AXIS_W-1:0] vec_t;
  typedef logic [2:0][LIN_W-1:0]  lin_vec_t;

  // item held between the gravity stage and the result stage
  typedef struct packed {
    func_t             func;
    logic              proc;      // sample updated the history
    logic              check;     // still-exit check at batch end
    logic              charging;
    logic [TIME_W-1:0] now;
    vec_t              accel;
    vec_t              grav;      // newest history entry after the item
    vec_t              oldest;    // oldest history entry
  } s1_t;

  typedef struct packed {
    vec_t grav;
    logic still;
    logic wake;
  } res_t;

  // one axis of the gravity low-pass, truncated toward zero
  function automatic logic [AXIS_W-1:0] smooth(input logic [AXIS_W-1:0] prev,
                                               input logic [AXIS_W-1:0] a);
    logic signed [SMOOTH_W-1:0] acc;
    logic [MAG_W-1:0]           mag;
    logic [RECIP_PROD_W-1:0]    prod;
    logic [AXIS_W-1:0]          q;
    acc  = SMOOTH_W'($signed(prev)) * SMOOTH_W'(SMOOTH_WEIGHT) + SMOOTH_W'($signed(a));
    mag  = acc[SMOOTH_W-1] ? MAG_W'(-acc) : acc[MAG_W-1:0];
    prod = RECIP_PROD_W'(mag) * RECIP_PROD_W'(RECIP_10);
    q    = AXIS_W'(prod >> RECIP_SHIFT);
    return acc[SMOOTH_W-1] ? AXIS_W'(-q) : q;
  endfunction

endpackage

// File: rtl/wrist_raise_and_still_detector.sv
// wrist-raise and still detector: gravity stage, result stage and config registers
//
// channel  | dir | transfer moves
// s_*      | in  | one accelerometer sample or minute tick
// m_*      | out | one result: wake, still flag, gravity estimate
// cfg_*    | in  | one register write, no handshake
//
// two register stages: the gravity filter and history shift line, then the
// dot product, trackers and still logic into the output register.
// one item per cycle while the output is not stalled; a result passes through the
// first stage register and then the output register before it can leave.
// the gravity recurrence closes within the first stage, so nothing waits on it.
// rst clears the history, trackers, flags and valid bits and loads the register reset values.
// a stalled output holds its result; the first stage still fills behind it.
module wrist_raise_and_still_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // accel_x, accel_y, accel_z, motor_vibrated, first_of_batch, charging, now_seconds, zero pad
  input  logic [wrsd_pkg::IN_TDATA_W-1:0]      s_tdata,
  // func
  input  logic [0:0]                           s_tuser,
  // last_of_batch
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // wake_request, still_mode, gravity_x, gravity_y, gravity_z, zero pad
  output logic [wrsd_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [wrsd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [wrsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [wrsd_pkg::JITTER_W-1:0] jitter_limit;
  logic [wrsd_pkg::PERP_W-1:0]   perp_limit;
  logic [wrsd_pkg::TILT_W-1:0]   tilt_limit;
  logic [wrsd_pkg::HOLD_W-1:0]   hold_seconds;

  // first stage state
  wrsd_pkg::vec_t hist [wrsd_pkg::HIST_TAPS];
  logic           batch_aborted;
  logic           s1_valid;
  wrsd_pkg::s1_t  s1;

  // result stage state
  wrsd_pkg::lin_vec_t            trk_min;
  wrsd_pkg::lin_vec_t            trk_max;
  logic                          still_flag;
  logic [wrsd_pkg::TIME_W-1:0]   still_start;
  logic                          out_valid;
  wrsd_pkg::res_t                res;

  // input unpacking
  wrsd_pkg::func_t             in_func;
  wrsd_pkg::vec_t              in_accel;
  logic                        in_vib;
  logic                        in_first;
  logic                        in_charging;
  logic [wrsd_pkg::TIME_W-1:0] in_now;

  logic          out_en;
  logic          s1_en;
  logic          in_xfer;
  logic          in_proc;
  logic          in_check;
  logic          aborted_next;
  wrsd_pkg::vec_t g_new;

  // result stage combinational values
  wrsd_pkg::lin_vec_t          lin;
  wrsd_pkg::lin_vec_t          upd_min;
  wrsd_pkg::lin_vec_t          upd_max;
  wrsd_pkg::lin_vec_t          trk_min_next;
  wrsd_pkg::lin_vec_t          trk_max_next;
  logic                        still_next;
  logic [wrsd_pkg::TIME_W-1:0] start_next;
  logic                        wake_next;
  logic signed [wrsd_pkg::DOT_W-1:0] dot;
  logic                        rot_wake;

  assign in_func     = wrsd_pkg::func_t'(s_tuser[0]);
  assign in_accel[0] = s_tdata[12:0];
  assign in_accel[1] = s_tdata[25:13];
  assign in_accel[2] = s_tdata[38:26];
  assign in_vib      = s_tdata[39];
  assign in_first    = s_tdata[40];
  assign in_charging = s_tdata[41];
  assign in_now      = s_tdata[73:42];

  // handshake: each stage moves when the one after it has room
  assign out_en   = !out_valid || m_tready;
  assign s1_en    = !s1_valid || out_en;
  assign s_tready = s1_en;
  assign in_xfer  = s_tvalid && s1_en;

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, res.grav[2], res.grav[1], res.grav[0], res.still, res.wake};

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_limit <= wrsd_pkg::JITTER_RESET;
      perp_limit   <= wrsd_pkg::PERP_RESET;
      tilt_limit   <= wrsd_pkg::TILT_RESET;
      hold_seconds <= wrsd_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (wrsd_pkg::cfg_reg_t'(cfg_addr))
        wrsd_pkg::REG_JITTER: jitter_limit <= cfg_wdata[wrsd_pkg::JITTER_W-1:0];
        wrsd_pkg::REG_PERP:   perp_limit   <= cfg_wdata[wrsd_pkg::PERP_W-1:0];
        wrsd_pkg::REG_TILT:   tilt_limit   <= cfg_wdata[wrsd_pkg::TILT_W-1:0];
        wrsd_pkg::REG_HOLD:   hold_seconds <= cfg_wdata[wrsd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // batch marks and vibration abort decide whether a sample is used
  always_comb begin
    in_proc      = 1'b0;
    in_check     = 1'b0;
    aborted_next = batch_aborted;
    if (in_func == wrsd_pkg::FUNC_SAMPLE) begin
      if (in_first) begin
        aborted_next = 1'b0;
        in_check     = s_tlast;
      end else if (!batch_aborted) begin
        if (in_vib) begin
          aborted_next = 1'b1;
        end else begin
          in_proc  = 1'b1;
          in_check = s_tlast;
        end
      end
      if (s_tlast) begin
        aborted_next = 1'b0;
      end
    end
  end

  // gravity low-pass against the newest history entry
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_new[k] = wrsd_pkg::smooth(hist[0][k], in_accel[k]);
    end
  end

  // history shift line, newest entry in slot zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wrsd_pkg::HIST_TAPS; i++) begin
        hist[i] <= '0;
      end
      batch_aborted <= 1'b0;
    end else if (in_xfer) begin
      batch_aborted <= aborted_next;
      if (in_proc) begin
        hist[0] <= g_new;
        for (int i = 1; i < wrsd_pkg::HIST_TAPS; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end
  end

  // first stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1.func     <= in_func;
      s1.proc     <= in_proc;
      s1.check    <= in_check;
      s1.charging <= in_charging;
      s1.now      <= in_now;
      s1.accel    <= in_accel;
      s1.grav     <= in_proc ? g_new : hist[0];
      s1.oldest   <= hist[wrsd_pkg::HIST_TAPS-1];
    end
  end

  // rotation test: dot product with the oldest entry and tilt of y and z
  always_comb begin
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      dot = dot + wrsd_pkg::DOT_W'($signed(s1.grav[k]))
                * wrsd_pkg::DOT_W'($signed(s1.oldest[k]));
    end
    rot_wake = s1.proc
        && (dot > -$signed({2'b00, perp_limit}))
        && (dot < $signed({2'b00, perp_limit}))
        && ($signed(s1.grav[1]) < $signed(tilt_limit))
        && ($signed(s1.grav[2]) < $signed(tilt_limit));
  end

  // linear acceleration into the min/max trackers
  always_comb begin
    logic trk_empty;
    trk_empty = (trk_min[0] == '0) && (trk_min[1] == '0) && (trk_min[2] == '0);
    for (int k = 0; k < 3; k++) begin
      lin[k] = wrsd_pkg::LIN_W'($signed(s1.accel[k])) - wrsd_pkg::LIN_W'($signed(s1.grav[k]));
      upd_min[k] = trk_empty ? lin[k] : trk_min[k];
      upd_max[k] = trk_empty ? lin[k] : trk_max[k];
      if ($signed(lin[k]) < $signed(upd_min[k])) begin
        upd_min[k] = lin[k];
      end
      if ($signed(lin[k]) > $signed(upd_max[k])) begin
        upd_max[k] = lin[k];
      end
    end
  end

  // still mode entry on a tick, exit at batch end
  always_comb begin
    logic signed [wrsd_pkg::CMP_W-1:0] jl;
    logic signed [wrsd_pkg::CMP_W-1:0] zmin;
    logic signed [wrsd_pkg::CMP_W-1:0] zmax;
    logic [wrsd_pkg::TIME_W-1:0]       elapsed;
    jl           = $signed({2'b00, jitter_limit});
    trk_min_next = trk_min;
    trk_max_next = trk_max;
    still_next   = still_flag;
    start_next   = still_start;
    wake_next    = 1'b0;
    elapsed      = s1.now - still_start;
    if (s1.func == wrsd_pkg::FUNC_TICK) begin
      zmin = wrsd_pkg::CMP_W'($signed(trk_min[2]));
      zmax = wrsd_pkg::CMP_W'($signed(trk_max[2]));
      if (!still_flag) begin
        if ((zmax < jl) && (zmin > -jl)) begin
          if (!s1.charging) begin
            still_next = 1'b1;
            start_next = s1.now;
          end
        end else begin
          trk_min_next = '0;
          trk_max_next = '0;
        end
      end
    end else begin
      if (s1.proc) begin
        trk_min_next = upd_min;
        trk_max_next = upd_max;
      end
      zmin      = wrsd_pkg::CMP_W'($signed(trk_min_next[2]));
      zmax      = wrsd_pkg::CMP_W'($signed(trk_max_next[2]));
      wake_next = rot_wake;
      if (s1.check && still_flag && ((zmax > jl) || (zmin < -jl))) begin
        still_next = 1'b0;
        if (elapsed > wrsd_pkg::TIME_W'(hold_seconds)) begin
          wake_next = 1'b1;
        end
      end
    end
  end

  // result stage state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      trk_min     <= '0;
      trk_max     <= '0;
      still_flag  <= 1'b0;
      still_start <= '0;
      out_valid   <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        trk_min     <= trk_min_next;
        trk_max     <= trk_max_next;
        still_flag  <= still_next;
        still_start <= start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      res.wake  <= wake_next;
      res.still <= still_next;
      res.grav  <= s1.grav;
    end
  end

  // gravity history moves only on a transfer
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(hist[0]) && $stable(hist[wrsd_pkg::HIST_TAPS-1]))
    else $error("gravity history changed without an input transfer");

  // trackers keep minimum at or below maximum on every axis
  a_trk_order: assert property (@(posedge clk) disable iff (rst)
    ($signed(trk_min[0]) <= $signed(trk_max[0]))
    && ($signed(trk_min[1]) <= $signed(trk_max[1]))
    && ($signed(trk_min[2]) <= $signed(trk_max[2])))
    else $error("motion tracker minimum above maximum");

  // still mode is entered only by a minute tick leaving the first stage
  a_still_entry: assert property (@(posedge clk) disable iff (rst)
    (!still_flag && !(s1_valid && out_en && s1.func == wrsd_pkg::FUNC_TICK)) |=> !still_flag)
    else $error("still mode entered without a minute tick");

  // the end of a batch always clears the abort mark
  a_abort_clear: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_func == wrsd_pkg::FUNC_SAMPLE && s_tlast) |=> !batch_aborted)
    else $error("batch abort mark survived the end of a batch");

endmodule

// File: test/testbench.sv
// testbench for the wrist-raise and still detector: stream driver, result monitor, predictor
`timescale 1ns / 100ps

module testbench;

  localparam int IDLE_PCT  = 24;
  localparam int MAX_SHOWN = 10;
  localparam int AXIS_MAX  = 4095;
  localparam int AXIS_MIN  = -4096;

  // one sample or tick as the sender sees it
  typedef struct {
    wrsd_pkg::func_t    func;
    logic signed [12:0] ax, ay, az;
    logic               vib, first, last, chg;
    logic [31:0]        now;
  } motion_item_t;

  // one result as it leaves the block
  typedef struct {
    logic               wake, still;
    logic signed [12:0] gx, gy, gz;
  } wake_report_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  // accel_x, accel_y, accel_z, motor_vibrated, first_of_batch, charging, now_seconds, zero pad
  logic [wrsd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  // func
  logic [0:0]                       s_tuser = '0;
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  // wake_request, still_mode, gravity_x, gravity_y, gravity_z, zero pad
  logic [wrsd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_we = 1'b0;
  logic [wrsd_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [wrsd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  motion_item_t sample_fifo[$];
  wake_report_t report_fifo[$];
  motion_item_t in_flight;
  wake_report_t got, want;
  bit           steady = 1'b0;

  int fault_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int wakes_seen = 0;
  int still_entries = 0;
  int still_exits = 0;

  // predictor state and its copy of the limit registers
  int          ring_x[wrsd_pkg::HIST_DEPTH];
  int          ring_y[wrsd_pkg::HIST_DEPTH];
  int          ring_z[wrsd_pkg::HIST_DEPTH];
  int          ring_ptr = 0;
  int          lin_lo[3];
  int          lin_hi[3];
  bit          still_on = 1'b0;
  logic [31:0] still_since = '0;
  bit          batch_dropped = 1'b0;
  int unsigned lim_jitter = wrsd_pkg::JITTER_RESET;
  int unsigned lim_perp = wrsd_pkg::PERP_RESET;
  int          lim_tilt = -600;
  int unsigned lim_hold = wrsd_pkg::HOLD_RESET;

  // stimulus generator state
  int          ori[3];
  logic [31:0] clock_s = 32'd1000;

  wrist_raise_and_still_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected result of one accepted item, state advanced alongside
  task automatic predict_report(input motion_item_t it);
    wake_report_t r;
    int          a[3];
    int          g[3];
    int          lin[3];
    int          p, n, o, jl, k;
    longint      dot;
    bit          check, wake;
    logic [31:0] held;
    check = 1'b0;
    wake  = 1'b0;
    jl    = int'(lim_jitter);
    a[0]  = it.ax;
    a[1]  = it.ay;
    a[2]  = it.az;
    if (it.func == wrsd_pkg::FUNC_TICK) begin
      if (!still_on) begin
        if (lin_hi[2] < jl && lin_lo[2] > -jl) begin
          if (!it.chg) begin
            still_on    = 1'b1;
            still_since = it.now;
            still_entries++;
          end
        end else begin
          lin_lo = '{0, 0, 0};
          lin_hi = '{0, 0, 0};
        end
      end
    end else begin
      if (it.first) begin
        batch_dropped = 1'b0;
        check = it.last;
      end else if (!batch_dropped) begin
        if (it.vib) begin
          batch_dropped = 1'b1;
        end else begin
          // gravity low-pass into the ring, compared with the oldest entry
          p = ring_ptr;
          n = (p + 1) % wrsd_pkg::HIST_DEPTH;
          o = (n + 1) % wrsd_pkg::HIST_DEPTH;
          g[0] = (ring_x[p] * 9 + a[0]) / 10;
          g[1] = (ring_y[p] * 9 + a[1]) / 10;
          g[2] = (ring_z[p] * 9 + a[2]) / 10;
          ring_x[n] = g[0];
          ring_y[n] = g[1];
          ring_z[n] = g[2];
          ring_ptr  = n;
          dot = longint'(g[0]) * ring_x[o] + longint'(g[1]) * ring_y[o]
              + longint'(g[2]) * ring_z[o];
          if (dot > -longint'(lim_perp) && dot < longint'(lim_perp)
              && g[1] < lim_tilt && g[2] < lim_tilt)
            wake = 1'b1;
          // linear acceleration trackers, loaded afresh when cleared
          for (k = 0; k < 3; k++) lin[k] = a[k] - g[k];
          if (lin_lo[0] == 0 && lin_lo[1] == 0 && lin_lo[2] == 0) begin
            lin_lo = lin;
            lin_hi = lin;
          end
          for (k = 0; k < 3; k++) begin
            if (lin_lo[k] > lin[k]) lin_lo[k] = lin[k];
            if (lin_hi[k] < lin[k]) lin_hi[k] = lin[k];
          end
          check = it.last;
        end
      end
      // still exit at the end of a batch
      if (check && still_on && (lin_hi[2] > jl || lin_lo[2] < -jl)) begin
        still_on = 1'b0;
        still_exits++;
        held = it.now - still_since;
        if (held > lim_hold) wake = 1'b1;
      end
      if (it.last) batch_dropped = 1'b0;
    end
    r.wake  = wake;
    r.still = still_on;
    r.gx    = 13'(ring_x[ring_ptr]);
    r.gy    = 13'(ring_y[ring_ptr]);
    r.gz    = 13'(ring_z[ring_ptr]);
    report_fifo.push_back(r);
  endtask

  // sender: predict on each transfer, then present the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_report(in_flight);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (sample_fifo.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_flight = sample_fifo.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, in_flight.now, in_flight.chg, in_flight.first, in_flight.vib,
                       in_flight.az, in_flight.ay, in_flight.ax};
          s_tuser  <= in_flight.func;
          s_tlast  <= in_flight.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, each transfer checked against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (m_tvalid && m_tready) begin
        got.wake  = m_tdata[0];
        got.still = m_tdata[1];
        got.gx    = m_tdata[14:2];
        got.gy    = m_tdata[27:15];
        got.gz    = m_tdata[40:28];
        if (report_fifo.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_SHOWN)
            $display("unexpected result: wake %0b still %0b g (%0d %0d %0d)",
                     got.wake, got.still, got.gx, got.gy, got.gz);
        end else begin
          want = report_fifo.pop_front();
          results_checked++;
          if (got.wake) wakes_seen++;
          if (got.wake != want.wake || got.still != want.still || got.gx != want.gx
              || got.gy != want.gy || got.gz != want.gz) begin
            fault_count++;
            if (fault_count <= MAX_SHOWN)
              $display("result %0d mismatch: expected wake %0b still %0b g (%0d %0d %0d),",
                       results_checked, want.wake, want.still, want.gx, want.gy, want.gz,
                       " got wake %0b still %0b g (%0d %0d %0d)",
                       got.wake, got.still, got.gx, got.gy, got.gz);
          end
        end
      end
    end
  end

  function automatic logic signed [12:0] clamp_axis(input int v);
    if (v > AXIS_MAX) return 13'(AXIS_MAX);
    if (v < AXIS_MIN) return 13'(AXIS_MIN);
    return 13'(v);
  endfunction

  function automatic void push_item(input wrsd_pkg::func_t f, input int ax, input int ay,
                                    input int az, input bit vib, input bit first,
                                    input bit last, input bit chg, input logic [31:0] now);
    motion_item_t it;
    it.func  = f;
    it.ax    = clamp_axis(ax);
    it.ay    = clamp_axis(ay);
    it.az    = clamp_axis(az);
    it.vib   = vib;
    it.first = first;
    it.last  = last;
    it.chg   = chg;
    it.now   = now;
    sample_fifo.push_back(it);
  endfunction

  // write all four limits while the block is idle
  task automatic apply_limits(input int unsigned jit, input int unsigned perp,
                              input int tilt, input int unsigned hold);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= wrsd_pkg::REG_JITTER;
    cfg_wdata <= wrsd_pkg::CFG_DATA_W'(13'(jit));
    @(posedge clk);
    cfg_addr  <= wrsd_pkg::REG_PERP;
    cfg_wdata <= wrsd_pkg::CFG_DATA_W'(perp);
    @(posedge clk);
    cfg_addr  <= wrsd_pkg::REG_TILT;
    cfg_wdata <= wrsd_pkg::CFG_DATA_W'(13'(tilt));
    @(posedge clk);
    cfg_addr  <= wrsd_pkg::REG_HOLD;
    cfg_wdata <= wrsd_pkg::CFG_DATA_W'(16'(hold));
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_jitter = jit;
    lim_perp   = perp;
    lim_tilt   = tilt;
    lim_hold   = hold;
  endtask

  // hold the sender until every expected result has come, then let the pipe settle
  task automatic drain();
    while (sample_fifo.size() != 0 || s_tvalid || report_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed batches around a held orientation, plus ticks and noise
  task automatic add_random_traffic(input int quota);
    int made, len, amp, k, pick;
    bit no_first;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(5))
          0: ori = '{1000, 0, 0};
          1: ori = '{0, -1000, 0};
          2: ori = '{0, -750, -750};
          3: ori = '{0, 0, -1000};
          4: ori = '{-700, -700, 0};
          default: ori = '{$urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                           $urandom_range(8191) - 4096};
        endcase
      end
      if (pick < 15) begin
        // minute tick
        clock_s = clock_s + $urandom_range(20, 70);
        push_item(wrsd_pkg::FUNC_TICK, $urandom_range(8191) - 4096,
                  $urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                  $urandom_range(1), $urandom_range(1), $urandom_range(1),
                  $urandom_range(4) == 0, clock_s);
        made++;
      end else if (pick < 23) begin
        // noise: any field at any value
        if ($urandom_range(3) == 0) clock_s = $urandom();
        push_item(wrsd_pkg::func_t'($urandom_range(1)), $urandom_range(8191) - 4096,
                  $urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                  $urandom_range(1), $urandom_range(1), $urandom_range(1),
                  $urandom_range(1), $urandom());
        made++;
      end else if (pick < 30) begin
        // lone first sample that also closes the batch
        clock_s = clock_s + $urandom_range(2);
        push_item(wrsd_pkg::FUNC_SAMPLE, $urandom_range(8191) - 4096,
                  $urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                  $urandom_range(1), 1'b1, 1'b1, $urandom_range(1), clock_s);
        made++;
      end else begin
        case ($urandom_range(9))
          0, 1, 2:       amp = $urandom_range(15);
          3, 4, 5, 6, 7: amp = $urandom_range(150);
          default:       amp = $urandom_range(2000);
        endcase
        len      = $urandom_range(1, 10);
        no_first = ($urandom_range(19) == 0);
        if (!no_first) begin
          push_item(wrsd_pkg::FUNC_SAMPLE, $urandom_range(8191) - 4096,
                    $urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                    $urandom_range(1), 1'b1, 1'b0, $urandom_range(1), clock_s);
          made++;
        end
        for (k = 0; k < len; k++) begin
          clock_s = clock_s + $urandom_range(2);
          pick = ($urandom_range(32) == 0);
          push_item(wrsd_pkg::FUNC_SAMPLE, ori[0] + $urandom_range(2 * amp) - amp,
                    ori[1] + $urandom_range(2 * amp) - amp,
                    ori[2] + $urandom_range(2 * amp) - amp,
                    pick[0], 1'b0, k == len - 1, $urandom_range(1), clock_s);
          made++;
        end
      end
    end
  endtask

  initial begin
    int ph;
    lin_lo = '{0, 0, 0};
    lin_hi = '{0, 0, 0};
    ori    = '{0, -750, -750};
    for (ph = 0; ph < wrsd_pkg::HIST_DEPTH; ph++) begin
      ring_x[ph] = 0;
      ring_y[ph] = 0;
      ring_z[ph] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: charging and plain ticks, abort, lone batch with still exit and wake,
    // clock wrap, rotation wake, tracker clear, sample with no batch start
    push_item(wrsd_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 1, 32'd100);
    push_item(wrsd_pkg::FUNC_TICK, AXIS_MAX, AXIS_MIN, AXIS_MAX, 1, 1, 1, 0, 32'd100);
    push_item(wrsd_pkg::FUNC_SAMPLE, AXIS_MIN, AXIS_MAX, -1, 1, 1, 0, 0, 32'd101);
    push_item(wrsd_pkg::FUNC_SAMPLE, AXIS_MAX, AXIS_MAX, AXIS_MAX, 0, 0, 0, 1, 32'd102);
    push_item(wrsd_pkg::FUNC_SAMPLE, AXIS_MIN, AXIS_MIN, AXIS_MIN, 1, 0, 0, 0, 32'd103);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 32'd104);
    push_item(wrsd_pkg::FUNC_SAMPLE, 1, 1, 1, 0, 0, 1, 0, 32'd105);
    push_item(wrsd_pkg::FUNC_SAMPLE, 5, -5, 5, 0, 1, 1, 0, 32'd200);
    push_item(wrsd_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 32'd210);
    push_item(wrsd_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFF0);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 1, 0, 0, 32'hFFFF_FFF8);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, AXIS_MIN, AXIS_MIN, 0, 0, 0, 0, 32'h0000_0008);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, AXIS_MIN, AXIS_MIN, 0, 0, 0, 0, 32'h0000_000C);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, AXIS_MIN, AXIS_MIN, 0, 0, 0, 0, 32'h0000_000E);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, AXIS_MIN, AXIS_MIN, 0, 0, 1, 0, 32'h0000_0010);
    push_item(wrsd_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0020);
    push_item(wrsd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 1, 0, 0, 32'h0000_0021);
    push_item(wrsd_pkg::FUNC_SAMPLE, AXIS_MAX, AXIS_MIN, 0, 0, 0, 0, 0, 32'h0000_0022);
    push_item(wrsd_pkg::FUNC_SAMPLE, 7, 7, 7, 1, 0, 1, 0, 32'h0000_0023);
    push_item(wrsd_pkg::FUNC_SAMPLE, AXIS_MAX, -1, AXIS_MIN, 0, 0, 0, 1, 32'hFFFF_FFFF);
    add_random_traffic(280);
    drain();

    // limit sweeps: wide open, shut, two random midrange sets, back to defaults
    for (ph = 1; ph < 6; ph++) begin
      case (ph)
        1: apply_limits(8191, 67108863, 4095, 0);
        2: apply_limits(0, 0, -4096, 65535);
        3, 4: apply_limits($urandom_range(50, 400), $urandom_range(20000, 300000),
                           $urandom_range(600) - 900, $urandom_range(200));
        default: apply_limits(200, 100000, -600, 60);
      endcase
      steady = (ph == 3);
      add_random_traffic(320);
      drain();
      steady = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (report_fifo.size() != 0) begin
      fault_count++;
      $display("%0d expected results never arrived", report_fifo.size());
    end
    $display("%0d items sent over six limit settings, %0d results checked",
             items_sent, results_checked);
    $display("%0d wake requests, %0d still entries, %0d still exits, %0d mismatches",
             wakes_seen, still_entries, still_exits, fault_count);
    if (fault_count == 0) begin
      $display("[wrist_raise_and_still_detector] OK");
    end else begin
      $display("[wrist_raise_and_still_detector] ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", report_fifo.size());
    $display("[wrist_raise_and_still_detector] ERROR");
    $finish;
  end

endmodule
